### rtl/core/ttar_pkg.sv
// Package for the tag table age replacement unit: defaults, controller states and command types.
package ttar_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned KeyBitsDef = 64;
  localparam int unsigned AgeBitsDef = 16;

  localparam int unsigned KeyPortW  = 64;
  localparam int unsigned SlotPortW = 4;

  typedef enum logic {
    ActLookup = 1'b0,
    ActInsert = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StScanWait,
    StDecide,
    StAge,
    StAgeWait,
    StDone
  } ctrl_state_e;

  typedef struct packed {
    logic start;     // latch request, clear scan index and trackers
    logic age_start; // clear scan index for the aging pass
    logic rd_en;     // read entry at scan index, advance index
    logic age;       // issued read belongs to the aging pass
    logic commit;    // mark the chosen slot valid
    logic load_out;  // load result into the output register
  } ttar_cmd_t;

  typedef struct packed {
    logic last_rd;   // scan index is at the final entry
    logic insert;    // latched request is an insert
    logic found;     // insert has a usable slot
    logic out_free;  // output register can take a result
  } ttar_stat_t;

endpackage

### rtl/core/ttar_ctrl.sv
// Controller state machine that sequences the scan and aging passes.
module ttar_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ttar_pkg::ttar_stat_t stat_i,
  output ttar_pkg::ttar_cmd_t  cmd_o
);
  import ttar_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StScan;
      end
      StScan: begin
        if (stat_i.last_rd) state_d = StScanWait;
      end
      StScanWait: state_d = StDecide;
      StDecide: begin
        if (stat_i.insert && stat_i.found) state_d = StAge;
        else state_d = StDone;
      end
      StAge: begin
        if (stat_i.last_rd) state_d = StAgeWait;
      end
      StAgeWait: state_d = StDone;
      StDone: begin
        if (stat_i.out_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      StScan: cmd_o.rd_en = 1'b1;
      StDecide: cmd_o.age_start = stat_i.insert && stat_i.found;
      StAge: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.age   = 1'b1;
      end
      StAgeWait: cmd_o.commit = 1'b1;
      StDone: cmd_o.load_out = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/ttar_dp.sv
// Datapath: entry memory, valid bits, scan pipeline, victim trackers and output register.
module ttar_dp #(
  parameter int unsigned Entries = ttar_pkg::EntriesDef,
  parameter int unsigned KeyBits = ttar_pkg::KeyBitsDef,
  parameter int unsigned AgeBits = ttar_pkg::AgeBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              action_i,
  input  logic [ttar_pkg::KeyPortW-1:0]     key_i,
  input  ttar_pkg::ttar_cmd_t               cmd_i,
  output ttar_pkg::ttar_stat_t              stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [ttar_pkg::SlotPortW-1:0]    slot_o,
  output logic                              failed_o
);
  import ttar_pkg::*;

  localparam int unsigned IdxW  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned WordW = KeyBits + AgeBits;

  // entry memory word: {key, age}
  logic [WordW-1:0]   mem [Entries];
  logic [Entries-1:0] valid_q;

  logic [IdxW-1:0]    rd_idx_q;
  logic [WordW-1:0]   rdata_q;
  logic [IdxW-1:0]    cidx_q;
  logic               cvld_q;
  logic               cage_q;

  logic               action_q;
  logic [KeyBits-1:0] key_q;

  logic               hit_q;
  logic [IdxW-1:0]    hit_slot_q;
  logic               empty_q;
  logic [AgeBits-1:0] best_q;
  logic [IdxW-1:0]    pick_q;

  logic               out_valid_q;
  logic               hit_out_q;
  logic [IdxW-1:0]    slot_out_q;
  logic               failed_out_q;

  logic [KeyBits-1:0] c_key;
  logic [AgeBits-1:0] c_age;
  logic               c_vld;
  logic               found;
  logic               we;
  logic [WordW-1:0]   wdata;
  logic [IdxW+SlotPortW-1:0] slot_ext;

  assign c_key = rdata_q[WordW-1:AgeBits];
  assign c_age = rdata_q[AgeBits-1:0];
  assign c_vld = valid_q[cidx_q];
  assign found = empty_q || (best_q != '0);

  assign stat_o.last_rd  = (rd_idx_q == IdxW'(Entries - 1));
  assign stat_o.insert   = (action_q == ActInsert);
  assign stat_o.found    = found;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // aging pass: refill the chosen slot, age every other valid entry short of saturation
  always_comb begin
    we    = 1'b0;
    wdata = rdata_q;
    if (cvld_q && cage_q) begin
      if (cidx_q == pick_q) begin
        we    = 1'b1;
        wdata = {key_q, {AgeBits{1'b0}}};
      end else if (c_vld && (c_age != {AgeBits{1'b1}})) begin
        we    = 1'b1;
        wdata = {c_key, c_age + AgeBits'(1)};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[cidx_q] <= wdata;
    if (cmd_i.rd_en) rdata_q <= mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_idx_q <= '0;
      cvld_q   <= 1'b0;
      cage_q   <= 1'b0;
    end else begin
      cvld_q <= cmd_i.rd_en;
      cage_q <= cmd_i.age;
      if (cmd_i.start || cmd_i.age_start) begin
        rd_idx_q <= '0;
      end else if (cmd_i.rd_en && !stat_o.last_rd) begin
        rd_idx_q <= rd_idx_q + IdxW'(1);
      end
      if (cmd_i.commit) valid_q[pick_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    cidx_q <= rd_idx_q;
  end

  // request latch and scan trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      action_q   <= ActLookup;
      key_q      <= '0;
      hit_q      <= 1'b0;
      hit_slot_q <= '0;
      empty_q    <= 1'b0;
      best_q     <= '0;
      pick_q     <= '0;
    end else if (cmd_i.start) begin
      action_q   <= action_i;
      key_q      <= key_i[KeyBits-1:0];
      hit_q      <= 1'b0;
      hit_slot_q <= '0;
      empty_q    <= 1'b0;
      best_q     <= '0;
      pick_q     <= '0;
    end else if (cvld_q && !cage_q) begin
      if (action_q == ActLookup) begin
        if (c_vld && (c_key == key_q) && !hit_q) begin
          hit_q      <= 1'b1;
          hit_slot_q <= cidx_q;
        end
      end else if (!empty_q) begin
        // lowest empty slot wins; else the first slot of greatest age
        if (!c_vld) begin
          empty_q <= 1'b1;
          pick_q  <= cidx_q;
        end else if (c_age > best_q) begin
          best_q <= c_age;
          pick_q <= cidx_q;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      if (action_q == ActLookup) begin
        hit_out_q    <= hit_q;
        slot_out_q   <= hit_q ? hit_slot_q : '0;
        failed_out_q <= 1'b0;
      end else begin
        hit_out_q    <= 1'b0;
        slot_out_q   <= found ? pick_q : '0;
        failed_out_q <= !found;
      end
    end
  end

  assign slot_ext    = {{SlotPortW{1'b0}}, slot_out_q};
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_out_q;
  assign slot_o      = slot_ext[SlotPortW-1:0];
  assign failed_o    = failed_out_q;

endmodule

### rtl/core/tag_table_age_replacement_unit.sv
// Top level of the tag table age replacement unit.
// Fully associative table of Entries slots, each with a valid bit, a key and a saturating
// age. One transaction at a time: a lookup scans every slot once and reports the lowest
// valid match. An insert scans once to choose the lowest empty slot or else the first
// slot of greatest nonzero age, then makes a second pass that writes the new key with age
// zero and ages every other valid slot. Both passes use the single read port of the entry
// memory, visited one slot per cycle, and a finished transaction waits while an unread
// earlier result holds the output register. An insert into a full table whose ages are
// all zero fails and leaves the table unchanged. A finished result waits in an output
// register, so the next request is taken while it is still unread. Reset empties the
// table at once; no clearing pass is needed.
module tag_table_age_replacement_unit #(
  parameter int unsigned Entries = ttar_pkg::EntriesDef,
  parameter int unsigned KeyBits = ttar_pkg::KeyBitsDef,
  parameter int unsigned AgeBits = ttar_pkg::AgeBitsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           action_i,
  input  logic [ttar_pkg::KeyPortW-1:0]  key_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [ttar_pkg::SlotPortW-1:0] slot_o,
  output logic                           failed_o
);
  import ttar_pkg::*;

  ttar_cmd_t  cmd;
  ttar_stat_t stat;

  ttar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ttar_dp #(
    .Entries (Entries),
    .KeyBits (KeyBits),
    .AgeBits (AgeBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .action_i    (action_i),
    .key_i       (key_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hit_o       (hit_o),
    .slot_o      (slot_o),
    .failed_o    (failed_o)
  );

`ifndef SYNTHESIS
  // a hit and a failure never come together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && failed_o))
    else $error("hit and failed both set");

  // a failed insert reports slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && failed_o) |-> (slot_o == '0))
    else $error("failed insert with nonzero slot");

  // an accepted transaction keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready right after acceptance");

  // the scan only issues reads while a transaction is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd_en |-> !in_ready_o)
    else $error("entry read while idle");
`endif

endmodule
